FILE: rtl/json_string_unescape_utf8_macros.svh
// Assertion macros for the JSON string unescaper.
// Included by the RTL files that carry concurrent checks; depends on nothing.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define JSU_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked out of reset
`define JSU_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define JSU_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define JSU_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: rtl/jsu_pkg.sv
// Types, character codes and decode helpers for the JSON string unescaper.
// Stand-alone package; used by json_string_unescape_utf8.
package jsu_pkg;

    localparam int MAX_RES  = 6;
    localparam int BODY_MAX = 4;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TEXT = 2'd1,
        PH_ESC  = 2'd2,
        PH_HEX  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } res_t;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
    } utf8_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] val;
    } opt_byte_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } opt_nib_t;

    // UTF-8 form of a code point, first byte in bytes[0]
    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t r;
        r = '0;
        if (cp < 21'h80) begin
            r.len      = 3'd1;
            r.bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            r.len      = 3'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            r.len      = 3'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            r.len      = 3'd4;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    function automatic opt_nib_t hex_digit(input logic [7:0] b);
        opt_nib_t r;
        r = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r.ok  = 1'b1;
            r.val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r.ok  = 1'b1;
            r.val = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r.ok  = 1'b1;
            r.val = 4'(b - 8'h37);
        end
        return r;
    endfunction

    function automatic opt_byte_t simple_escape(input logic [7:0] b);
        opt_byte_t r;
        r = '0;
        case (b)
            8'h6E: r = '{ok: 1'b1, val: 8'h0A};   // n
            8'h74: r = '{ok: 1'b1, val: 8'h09};   // t
            8'h72: r = '{ok: 1'b1, val: 8'h0D};   // r
            8'h62: r = '{ok: 1'b1, val: 8'h08};   // b
            8'h66: r = '{ok: 1'b1, val: 8'h0C};   // f
            8'h2F: r = '{ok: 1'b1, val: 8'h2F};   // solidus
            8'h5C: r = '{ok: 1'b1, val: 8'h5C};   // backslash
            8'h22: r = '{ok: 1'b1, val: 8'h22};   // quote
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/json_string_unescape_utf8.sv
// JSON string unescaper, UTF-16 escapes to UTF-8: the first result beat is shown in the cycle after
// its input beat is taken; one input beat per cycle while each byte gives at most one result and
// m_tready stays high. A byte giving n results (up to six, e.g. unpaired surrogate then \u escape)
// holds the next input beat back while the result buffer drains, one beat per cycle while m_tready is high.
// aresetn is synchronous, active low: clears phase, surrogate flag and result buffer;
// after reset the block waits for an opening quote.
// Depends on jsu_pkg and json_string_unescape_utf8_macros.svh.
`include "json_string_unescape_utf8_macros.svh"

module json_string_unescape_utf8 (
    input  logic       aclk,
    input  logic       aresetn,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic [1:0] m_tuser,    // [1:0] kind
    output logic       m_tlast     // last
);
    import jsu_pkg::*;

    // decode state, advanced once per accepted input beat
    phase_t      phase_reg,  phase_next;
    logic [1:0]  hex_reg,    hex_next;
    logic [11:0] accum_reg,  accum_next;   // up to three hex digits gathered
    logic [9:0]  pend_reg,   pend_next;    // held high surrogate minus 0xD800
    logic        pendv_reg,  pendv_next;

    // result buffer: written whole on accept, drained one beat per cycle while m_tready is high
    res_t        rbuf_reg [MAX_RES];
    res_t        rbuf_next [MAX_RES];
    logic [2:0]  cnt_reg;
    logic [2:0]  rd_reg;

    logic        s_acc;
    logic        m_acc;
    logic        do_flush;
    logic        use_enc;
    logic [20:0] cp;
    logic [15:0] unit;
    logic [2:0]  body_len;
    logic [2:0]  res_len;
    res_t        body [BODY_MAX];
    res_t        flush [3];
    utf8_t       enc;
    utf8_t       fenc;
    opt_nib_t    hexd;
    opt_byte_t   esc;

    assign m_tvalid = (rd_reg != cnt_reg);
    assign m_tlast  = m_tvalid && (3'(rd_reg + 3'd1) == cnt_reg);
    assign m_tdata  = rbuf_reg[rd_reg].data;
    assign m_tuser  = rbuf_reg[rd_reg].kind;

    // take a new beat when the buffer is empty or its final beat leaves now
    assign s_tready = !m_tvalid || (m_tready && m_tlast);
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;

    assign hexd = hex_digit(s_tdata);
    assign esc  = simple_escape(s_tdata);
    assign unit = {accum_reg, hexd.val};

    // held surrogate always flushes as a three-byte sequence
    assign fenc = utf8_encode({5'b0, 6'b110110, pend_reg});

    // next decode state and the run of results for this byte
    always_comb begin
        phase_next = phase_reg;
        hex_next   = hex_reg;
        accum_next = accum_reg;
        pend_next  = pend_reg;
        pendv_next = pendv_reg;
        do_flush   = 1'b0;
        use_enc    = 1'b0;
        cp         = '0;
        body_len   = 3'd0;
        for (int k = 0; k < BODY_MAX; k++) begin
            body[k] = '{kind: KIND_DATA, data: 8'h00};
        end

        case (phase_reg)
            PH_IDLE: begin
                if (s_tdata == CH_QUOTE) begin
                    phase_next = PH_TEXT;
                end else begin
                    body[0]  = '{kind: KIND_ERR, data: 8'h00};
                    body_len = 3'd1;
                end
            end
            PH_TEXT: begin
                if (s_tdata == CH_BSLASH) begin
                    phase_next = PH_ESC;
                end else if (s_tdata == CH_NUL) begin
                    phase_next = PH_IDLE;
                    pendv_next = 1'b0;
                    body[0]    = '{kind: KIND_ERR, data: 8'h00};
                    body_len   = 3'd1;
                end else begin
                    do_flush   = pendv_reg;
                    pendv_next = 1'b0;
                    body_len   = 3'd1;
                    if (s_tdata == CH_QUOTE) begin
                        // closing quote: end of string
                        phase_next = PH_IDLE;
                        body[0]    = '{kind: KIND_END, data: 8'h00};
                    end else begin
                        body[0] = '{kind: KIND_DATA, data: s_tdata};
                    end
                end
            end
            PH_ESC: begin
                if (s_tdata == CH_U) begin
                    phase_next = PH_HEX;
                    hex_next   = 2'd0;
                    accum_next = '0;
                end else if (!esc.ok) begin
                    phase_next = PH_IDLE;
                    pendv_next = 1'b0;
                    body[0]    = '{kind: KIND_ERR, data: 8'h00};
                    body_len   = 3'd1;
                end else begin
                    phase_next = PH_TEXT;
                    do_flush   = pendv_reg;
                    pendv_next = 1'b0;
                    body[0]    = '{kind: KIND_DATA, data: esc.val};
                    body_len   = 3'd1;
                end
            end
            PH_HEX: begin
                if (!hexd.ok) begin
                    phase_next = PH_IDLE;
                    hex_next   = 2'd0;
                    pendv_next = 1'b0;
                    body[0]    = '{kind: KIND_ERR, data: 8'h00};
                    body_len   = 3'd1;
                end else if (hex_reg == 2'd3) begin
                    phase_next = PH_TEXT;
                    hex_next   = 2'd0;
                    accum_next = '0;
                    if (pendv_reg && unit >= 16'hDC00 && unit <= 16'hDFFF) begin
                        // pair the held high surrogate with this low one
                        pendv_next = 1'b0;
                        use_enc    = 1'b1;
                        cp         = 21'h10000 + {1'b0, pend_reg, unit[9:0]};
                    end else begin
                        do_flush   = pendv_reg;
                        pendv_next = 1'b0;
                        if (unit >= 16'hD800 && unit <= 16'hDBFF) begin
                            pend_next  = unit[9:0];
                            pendv_next = 1'b1;
                        end else begin
                            use_enc = 1'b1;
                            cp      = {5'b0, unit};
                        end
                    end
                end else begin
                    accum_next = {accum_reg[7:0], hexd.val};
                    hex_next   = 2'(hex_reg + 2'd1);
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        enc = utf8_encode(cp);
        if (use_enc) begin
            for (int k = 0; k < BODY_MAX; k++) begin
                body[k] = '{kind: KIND_DATA, data: enc.bytes[k]};
            end
            body_len = enc.len;
        end
    end

    // flushed surrogate goes first, then this byte's own results
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            flush[k] = '{kind: KIND_DATA, data: fenc.bytes[k]};
        end
        for (int k = 0; k < MAX_RES; k++) begin
            rbuf_next[k] = '{kind: KIND_DATA, data: 8'h00};
        end
        if (do_flush) begin
            for (int k = 0; k < 3; k++) begin
                rbuf_next[k]     = flush[k];
                rbuf_next[k + 3] = body[k];
            end
            res_len = 3'(body_len + 3'd3);
        end else begin
            for (int k = 0; k < BODY_MAX; k++) begin
                rbuf_next[k] = body[k];
            end
            res_len = body_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            hex_reg   <= 2'd0;
            pendv_reg <= 1'b0;
            cnt_reg   <= 3'd0;
            rd_reg    <= 3'd0;
        end else if (s_acc) begin
            phase_reg <= phase_next;
            hex_reg   <= hex_next;
            pendv_reg <= pendv_next;
            cnt_reg   <= res_len;
            rd_reg    <= 3'd0;
        end else if (m_acc) begin
            rd_reg <= 3'(rd_reg + 3'd1);
        end
    end

    // payload: no reset needed
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            accum_reg <= accum_next;
            pend_reg  <= pend_next;
            for (int k = 0; k < MAX_RES; k++) begin
                rbuf_reg[k] <= rbuf_next[k];
            end
        end
    end

    `JSU_ASSERT_IMP(a_accept_only_on_drain, aclk, aresetn, s_acc, !m_tvalid || (m_tready && m_tlast), "input beat taken while results still queued")
    `JSU_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, cnt_reg <= 3'(MAX_RES) && rd_reg <= cnt_reg, "result pointer out of range")
    `JSU_ASSERT_IMP(a_pending_in_string, aclk, aresetn, pendv_reg, phase_reg != PH_IDLE, "surrogate held outside a string")
    `JSU_ASSERT_NXT(a_results_shown, aclk, aresetn, s_acc && res_len != 3'd0, m_tvalid && rd_reg == 3'd0, "results of accepted beat not presented")
    `JSU_ASSERT_NXT(a_drain_advances, aclk, aresetn, m_acc && !s_acc, rd_reg == 3'($past(rd_reg) + 3'd1), "result pointer failed to advance")

endmodule
